FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication at every rising clock edge outside reset.
`define BTA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/bta_pkg.sv
// Types and constants shared by the boundary-tag heap allocator modules.
`default_nettype none

package bta_pkg;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [6:0] MAX_RUN = 7'd64;

    // One classified operation as it travels from the front to the back.
    typedef struct packed {
        act_t       act;
        logic       bad;
        logic [7:0] need;
        logic [6:0] hdr;
        logic [6:0] addr;
        logic [7:0] wdata;
        logic [6:0] count;
    } op_t;

    // Status that the back reports to the front.
    typedef struct packed {
        logic init_busy;
    } bta_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/bta_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none
`include "assert_macros.svh"

module bta_front
    import bta_pkg::*;
#(
    parameter int HEAP_SIZE = 127
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] action,
    input  wire logic [6:0] request_size,
    input  wire logic [6:0] address,
    input  wire logic [7:0] write_data,
    input  wire logic [6:0] byte_count,
    input  wire bta_ctl_t   ctl,
    output logic            q_valid,
    output op_t             q_op,
    input  wire logic       q_pop
);

    localparam logic [7:0] HEAP_P = 8'(HEAP_SIZE);

    op_t        q_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    op_t        op_in;
    logic       push;

    always_comb
    begin
        op_in       = '0;
        op_in.act   = act_t'(action);
        op_in.need  = {1'b0, request_size} + 8'd2;
        op_in.hdr   = address - 7'd1;
        op_in.addr  = address;
        op_in.wdata = write_data;
        if (byte_count == 7'd0)
        begin
            op_in.count = 7'd1;
        end
        else if (byte_count > MAX_RUN)
        begin
            op_in.count = MAX_RUN;
        end
        else
        begin
            op_in.count = byte_count;
        end
        case (act_t'(action))
            ACT_FREE:  op_in.bad = (address == 7'd0) || ({1'b0, address} > HEAP_P);
            ACT_WRITE: op_in.bad = ({1'b0, address} >= HEAP_P);
            default:   op_in.bad = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != 2'd2) && !ctl.init_busy;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

    `BTA_ASSERT_IMP(a_no_pop_empty, q_pop, count_reg != 2'd0, "pop from an empty queue")
    `BTA_ASSERT_IMP(a_no_push_full, push, count_reg != 2'd2, "push into a full queue")
    `BTA_ASSERT(a_count_range, count_reg != 2'd3, "queue count beyond its depth")

endmodule

`default_nettype wire

FILE: rtl/core/bta_back.sv
// Back end: heap memory and the sequencer that walks, splits, clears and merges blocks and serves writes and reads.
`default_nettype none
`include "assert_macros.svh"

module bta_back
    import bta_pkg::*;
#(
    parameter int HEAP_SIZE = 127
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fit_policy,
    input  wire logic       q_valid,
    input  wire op_t        q_op,
    output logic            q_pop,
    output bta_ctl_t        ctl,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [6:0]      payload_start,
    output logic [7:0]      read_data,
    output logic            last_of_run
);

    localparam int         AW       = $clog2(HEAP_SIZE);
    localparam logic [7:0] HEAP_P   = 8'(HEAP_SIZE);
    localparam logic [7:0] TAG_INIT = 8'(HEAP_SIZE * 2);

    typedef enum logic [21:0] {
        S_INIT     = 22'h000001,
        S_IDLE     = 22'h000002,
        S_WALK_RD  = 22'h000004,
        S_WALK_CHK = 22'h000008,
        S_FIT      = 22'h000010,
        S_AL_HDR   = 22'h000020,
        S_AL_FRD   = 22'h000040,
        S_AL_FWR   = 22'h000080,
        S_AL_S1    = 22'h000100,
        S_AL_S2    = 22'h000200,
        S_AL_S3    = 22'h000400,
        S_FR_RD    = 22'h000800,
        S_FR_CHK   = 22'h001000,
        S_CLR      = 22'h002000,
        S_PREV     = 22'h004000,
        S_PREV_CHK = 22'h008000,
        S_NEXT     = 22'h010000,
        S_NEXT_CHK = 22'h020000,
        S_WR       = 22'h040000,
        S_RD_ISSUE = 22'h080000,
        S_RD_EMIT  = 22'h100000,
        S_RESP     = 22'h200000
    } state_t;

    logic [7:0] mem [HEAP_SIZE];
    logic [7:0] mem_rdata_reg;
    logic       mem_we;
    logic       mem_re;
    logic [7:0] mem_wa;
    logic [7:0] mem_ra;
    logic [7:0] mem_wd;

    state_t     state_reg,     state_next;
    state_t     ret_reg,       ret_next;
    op_t        op_reg,        op_next;
    logic [7:0] a_reg,         a_next;
    logic [7:0] best_a_reg,    best_a_next;
    logic [6:0] best_sz_reg,   best_sz_next;
    logic [6:0] best_diff_reg, best_diff_next;
    logic       found_reg,     found_next;
    logic [7:0] start_reg,     start_next;
    logic [7:0] end_reg,       end_next;
    logic [6:0] size_reg,      size_next;
    logic [7:0] clr_idx_reg,   clr_idx_next;
    logic [7:0] clr_end_reg,   clr_end_next;
    logic [7:0] tag_addr_reg,  tag_addr_next;
    logic [7:0] tag_data_reg,  tag_data_next;
    logic [6:0] k_reg,         k_next;
    logic [1:0] resp_st_reg,   resp_st_next;
    logic [6:0] resp_ps_reg,   resp_ps_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg,    status_next;
    logic [6:0] pstart_reg,    pstart_next;
    logic [7:0] rdata_reg,     rdata_next;
    logic       last_reg,      last_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_ra[AW-1:0]];
        end
    end

    always_comb
    begin
        logic [6:0] sz_rd;
        logic       free_rd;
        logic       can_emit;
        logic [7:0] end_sum;
        logic [6:0] diff;
        logic [6:0] rem;
        logic [7:0] total;
        logic [7:0] idx;
        logic       hit;

        sz_rd    = mem_rdata_reg[7:1];
        free_rd  = !mem_rdata_reg[0];
        can_emit = !out_valid_reg || out_ready;
        end_sum  = '0;
        diff     = sz_rd - op_reg.need[6:0];
        rem      = best_sz_reg - op_reg.need[6:0];
        total    = '0;
        idx      = {1'b0, op_reg.addr} + {1'b0, k_reg};
        hit      = 1'b0;

        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        best_a_next    = best_a_reg;
        best_sz_next   = best_sz_reg;
        best_diff_next = best_diff_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        size_next      = size_reg;
        clr_idx_next   = clr_idx_reg;
        clr_end_next   = clr_end_reg;
        tag_addr_next  = tag_addr_reg;
        tag_data_next  = tag_data_reg;
        k_next         = k_reg;
        resp_st_next   = resp_st_reg;
        resp_ps_next   = resp_ps_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        pstart_next    = pstart_reg;
        rdata_next     = rdata_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_re         = 1'b0;
        mem_ra         = '0;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                mem_wa = clr_idx_reg;
                mem_wd = (clr_idx_reg == 8'd0 || clr_idx_reg == HEAP_P - 8'd1) ? TAG_INIT : 8'd0;
                if (clr_idx_reg == HEAP_P - 8'd1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 8'd1;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    op_next = q_op;
                    case (q_op.act)
                        ACT_ALLOC:
                        begin
                            a_next     = 8'd0;
                            found_next = 1'b0;
                            state_next = S_WALK_RD;
                        end
                        ACT_FREE:
                        begin
                            if (q_op.bad)
                            begin
                                resp_st_next = ST_RANGE;
                                resp_ps_next = 7'd0;
                                state_next   = S_RESP;
                            end
                            else
                            begin
                                state_next = S_FR_RD;
                            end
                        end
                        ACT_WRITE:
                        begin
                            state_next = S_WR;
                        end
                        default:
                        begin
                            k_next     = 7'd0;
                            state_next = S_RD_ISSUE;
                        end
                    endcase
                end
            end
            S_WR:
            begin
                resp_ps_next = 7'd0;
                if (op_reg.bad)
                begin
                    resp_st_next = ST_RANGE;
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_wa       = {1'b0, op_reg.addr};
                    mem_wd       = op_reg.wdata;
                    resp_st_next = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = resp_st_reg;
                    pstart_next    = resp_ps_reg;
                    rdata_next     = 8'd0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                if (idx < HEAP_P)
                begin
                    mem_re = 1'b1;
                    mem_ra = idx;
                end
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = (idx < HEAP_P) ? ST_OK : ST_RANGE;
                    pstart_next    = 7'd0;
                    rdata_next     = (idx < HEAP_P) ? mem_rdata_reg : 8'd0;
                    last_next      = (k_reg == op_reg.count - 7'd1);
                    if (k_reg == op_reg.count - 7'd1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 7'd1;
                        state_next = S_RD_ISSUE;
                    end
                end
            end
            S_WALK_RD:
            begin
                if (a_reg >= HEAP_P)
                begin
                    state_next = S_FIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = a_reg;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                end_sum = a_reg + {1'b0, sz_rd};
                if (sz_rd == 7'd0 || end_sum > HEAP_P)
                begin
                    state_next = S_FIT;
                end
                else
                begin
                    if (free_rd && {1'b0, sz_rd} >= op_reg.need)
                    begin
                        if (!fit_policy)
                        begin
                            hit = 1'b1;
                        end
                        if (!fit_policy || !found_reg || diff < best_diff_reg)
                        begin
                            best_a_next    = a_reg;
                            best_sz_next   = sz_rd;
                            best_diff_next = diff;
                            found_next     = 1'b1;
                        end
                    end
                    a_next     = end_sum;
                    state_next = hit ? S_FIT : S_WALK_RD;
                end
            end
            S_FIT:
            begin
                if (!found_reg)
                begin
                    resp_st_next = ST_NOFIT;
                    resp_ps_next = 7'd0;
                    state_next   = S_RESP;
                end
                else
                begin
                    state_next = S_AL_HDR;
                end
            end
            S_AL_HDR:
            begin
                mem_we     = 1'b1;
                mem_wa     = best_a_reg;
                mem_wd     = {op_reg.need[6:0], 1'b1};
                state_next = ({1'b0, best_sz_reg} == op_reg.need) ? S_AL_FRD : S_AL_S1;
            end
            S_AL_FRD:
            begin
                mem_re     = 1'b1;
                mem_ra     = best_a_reg + {1'b0, best_sz_reg} - 8'd1;
                state_next = S_AL_FWR;
            end
            S_AL_FWR:
            begin
                mem_we       = 1'b1;
                mem_wa       = best_a_reg + {1'b0, best_sz_reg} - 8'd1;
                mem_wd       = mem_rdata_reg | 8'd1;
                resp_st_next = ST_OK;
                resp_ps_next = best_a_reg[6:0] + 7'd1;
                state_next   = S_RESP;
            end
            S_AL_S1:
            begin
                mem_we     = 1'b1;
                mem_wa     = best_a_reg + op_reg.need - 8'd1;
                mem_wd     = {op_reg.need[6:0], 1'b1};
                state_next = S_AL_S2;
            end
            S_AL_S2:
            begin
                mem_we     = 1'b1;
                mem_wa     = best_a_reg + op_reg.need;
                mem_wd     = {rem, 1'b0};
                state_next = S_AL_S3;
            end
            S_AL_S3:
            begin
                mem_we       = 1'b1;
                mem_wa       = best_a_reg + {1'b0, best_sz_reg} - 8'd1;
                mem_wd       = {rem, 1'b0};
                resp_st_next = ST_OK;
                resp_ps_next = best_a_reg[6:0] + 7'd1;
                state_next   = S_RESP;
            end
            S_FR_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = {1'b0, op_reg.hdr};
                state_next = S_FR_CHK;
            end
            S_FR_CHK:
            begin
                end_sum      = {1'b0, op_reg.hdr} + {1'b0, sz_rd};
                resp_ps_next = 7'd0;
                if (sz_rd == 7'd0 || end_sum > HEAP_P)
                begin
                    resp_st_next = ST_RANGE;
                    state_next   = S_RESP;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_wa        = {1'b0, op_reg.hdr};
                    mem_wd        = {sz_rd, 1'b0};
                    resp_st_next  = ST_OK;
                    clr_idx_next  = {1'b0, op_reg.hdr} + 8'd1;
                    clr_end_next  = end_sum - 8'd1;
                    tag_addr_next = end_sum - 8'd1;
                    tag_data_next = {sz_rd, 1'b0};
                    ret_next      = S_PREV;
                    start_next    = {1'b0, op_reg.hdr};
                    end_next      = end_sum - 8'd1;
                    size_next     = sz_rd;
                    state_next    = S_CLR;
                end
            end
            S_CLR:
            begin
                mem_we = 1'b1;
                if (clr_idx_reg < clr_end_reg)
                begin
                    mem_wa       = clr_idx_reg;
                    mem_wd       = 8'd0;
                    clr_idx_next = clr_idx_reg + 8'd1;
                end
                else
                begin
                    mem_wa     = tag_addr_reg;
                    mem_wd     = tag_data_reg;
                    state_next = ret_reg;
                end
            end
            S_PREV:
            begin
                if (start_reg != 8'd0)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = start_reg - 8'd1;
                    state_next = S_PREV_CHK;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_PREV_CHK:
            begin
                total = {1'b0, size_reg} + {1'b0, sz_rd};
                if (free_rd && sz_rd != 7'd0 && {1'b0, sz_rd} <= start_reg)
                begin
                    mem_we        = 1'b1;
                    mem_wa        = start_reg - {1'b0, sz_rd};
                    mem_wd        = {total[6:0], 1'b0};
                    clr_idx_next  = start_reg - 8'd1;
                    clr_end_next  = end_reg;
                    tag_addr_next = end_reg;
                    tag_data_next = {total[6:0], 1'b0};
                    ret_next      = S_NEXT;
                    start_next    = start_reg - {1'b0, sz_rd};
                    size_next     = total[6:0];
                    state_next    = S_CLR;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (end_reg < HEAP_P - 8'd1)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = end_reg + 8'd1;
                    state_next = S_NEXT_CHK;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_NEXT_CHK:
            begin
                total = {1'b0, size_reg} + {1'b0, sz_rd};
                if (free_rd && sz_rd != 7'd0 && end_reg + 8'd1 + {1'b0, sz_rd} <= HEAP_P)
                begin
                    mem_we        = 1'b1;
                    mem_wa        = start_reg;
                    mem_wd        = {total[6:0], 1'b0};
                    clr_idx_next  = start_reg + 8'd1;
                    clr_end_next  = start_reg + total - 8'd1;
                    tag_addr_next = start_reg + total - 8'd1;
                    tag_data_next = {total[6:0], 1'b0};
                    ret_next      = S_RESP;
                    state_next    = S_CLR;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ret_reg       <= S_IDLE;
            clr_idx_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        best_a_reg    <= best_a_next;
        best_sz_reg   <= best_sz_next;
        best_diff_reg <= best_diff_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        size_reg      <= size_next;
        clr_end_reg   <= clr_end_next;
        tag_addr_reg  <= tag_addr_next;
        tag_data_reg  <= tag_data_next;
        k_reg         <= k_next;
        resp_st_reg   <= resp_st_next;
        resp_ps_reg   <= resp_ps_next;
        status_reg    <= status_next;
        pstart_reg    <= pstart_next;
        rdata_reg     <= rdata_next;
        last_reg      <= last_next;
    end

    assign ctl.init_busy = (state_reg == S_INIT);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign payload_start = pstart_reg;
    assign read_data     = rdata_reg;
    assign last_of_run   = last_reg;

    `BTA_ASSERT_IMP(a_wr_in_heap, mem_we, mem_wa < HEAP_P, "heap write beyond the heap")
    `BTA_ASSERT(a_no_rd_wr, !(mem_we && mem_re), "heap read and write in the same cycle")
    `BTA_ASSERT_IMP(a_no_pop_init, state_reg == S_INIT, !q_pop, "queue popped during heap setup")

endmodule

`default_nettype wire

FILE: rtl/core/boundary_tag_heap_allocator_core.sv
// Top level of the boundary-tag heap allocator: configuration register, front end and back end.
// The back end serves one item at a time over the single heap memory port and takes no new
// item until it is through with the last one; the front queues up to two items meanwhile.
// Reset: asynchronous, active low; afterwards a setup pass writes the initial free block
// while input beats are held off (configuration writes are still taken).
`default_nettype none

module boundary_tag_heap_allocator_core
    import bta_pkg::*;
#(
    parameter int HEAP_SIZE = 127
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       fit_policy,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] action,
    input  wire logic [6:0] request_size,
    input  wire logic [6:0] address,
    input  wire logic [7:0] write_data,
    input  wire logic [6:0] byte_count,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [6:0]      payload_start,
    output logic [7:0]      read_data,
    output logic            last_of_run
);

    // The fit policy register selects first fit (0) or best fit (1) for the walk.
    logic     fit_policy_reg;
    logic     fit_policy_next;
    logic     q_valid;
    logic     q_pop;
    op_t      q_op;
    bta_ctl_t ctl;

    // The register may be written at any time; it is only sampled while an allocate walks.
    assign cfg_ready       = 1'b1;
    assign fit_policy_next = (cfg_valid && cfg_ready) ? fit_policy : fit_policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= 1'b0;
        end
        else
        begin
            fit_policy_reg <= fit_policy_next;
        end
    end

    // The front end classifies each beat and range-checks free and write addresses before queueing.
    bta_front #(
        .HEAP_SIZE (HEAP_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .request_size (request_size),
        .address      (address),
        .write_data   (write_data),
        .byte_count   (byte_count),
        .ctl          (ctl),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .q_pop        (q_pop)
    );

    // The back end owns the heap memory and produces every result beat through its
    // output register; a stalled consumer holds the back end, and the front queue keeps
    // taking beats until it is full.
    bta_back #(
        .HEAP_SIZE (HEAP_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fit_policy    (fit_policy_reg),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .ctl           (ctl),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .payload_start (payload_start),
        .read_data     (read_data),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire
